### rtl/core/pidw_pkg.sv
package pidw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int LIM_W     = 31;
  localparam int ERR_W     = 34;

  localparam logic KIND_CLEAR = 1'b1;

  // register map of the write port
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_OUTPUT_LIMIT = 3'd3,
    REG_WINDUP_LIMIT = 3'd4,
    REG_ANGLE_MODE   = 3'd5
  } pidw_reg_t;

  // angle wrap: one turn is WRAP_DIV << LOW_BITS in fixed point
  localparam int    WRAP_DIV    = 45;
  localparam int    WRAP_EXP    = 3;
  localparam int    LOW_BITS    = FRAC_BITS + WRAP_EXP;
  localparam int    HI_W        = ERR_W + 1 - LOW_BITS;
  localparam int    U_W         = HI_W + 1;
  localparam int    WRAP_OFFSET = ((1 << (HI_W - 1)) + WRAP_DIV - 1) / WRAP_DIV * WRAP_DIV;
  localparam int    RECIP_SHIFT = U_W + 6;
  localparam int    RECIP_W     = RECIP_SHIFT - 5;
  localparam int    WRAP_RECIP  = (1 << RECIP_SHIFT) / WRAP_DIV;
  localparam int    Q_W         = U_W - 5;
  localparam int    RC_W        = $clog2(WRAP_DIV);
  localparam int    BASE_W      = RC_W + LOW_BITS;
  localparam longint HALF_TURN  = 64'sd180 <<< FRAC_BITS;

  // product split: x = xh * 2^XL_W + xl
  localparam int XL_W   = ERR_W / 2;
  localparam int XH_W   = ERR_W - XL_W;
  localparam int MH_W   = DATA_W + XH_W;
  localparam int ML_W   = DATA_W + XL_W + 1;
  localparam int PROD_W = DATA_W + ERR_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic [LIM_W-1:0]         output_limit;
    logic [LIM_W-1:0]         windup_limit;
    logic                     angle_mode;
  } pidw_cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    kind;
    logic signed [ERR_W-1:0] err;
  } pidw_tag_t;

  typedef struct packed {
    logic                    kind;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] diff;
  } pidw_item_t;

  // floor((hi * 2^XL_W + lo) / 2^FRAC_BITS)
  function automatic logic signed [TERM_W-1:0] join_shift(
    input logic signed [MH_W-1:0] hi,
    input logic signed [ML_W-1:0] lo
  );
    logic signed [PROD_W-1:0] full;
    full = $signed({hi, {XL_W{1'b0}}}) + PROD_W'(lo);
    return full[PROD_W-1:FRAC_BITS];
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [SUM_W-1:0]  lim_s;
    logic signed [DATA_W-1:0] lim_d;
    lim_s = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
    lim_d = $signed({{(DATA_W-LIM_W){1'b0}}, lim});
    if (v >= lim_s) begin
      return lim_d;
    end else if (v < -lim_s) begin
      return -lim_d;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

### rtl/core/pidw_wrap.sv
module pidw_wrap import pidw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    angle_mode,
  input  pidw_tag_t               tag_in,
  input  logic signed [ERR_W-1:0] x_in,
  output pidw_tag_t               tag_out,
  output logic signed [ERR_W-1:0] x_out
);

  logic signed [ERR_W:0]    s;
  logic [HI_W-1:0]          hi;
  logic [U_W-1:0]           u_in;
  logic [U_W-1:0]           u1, u2;
  logic [LOW_BITS-1:0]      low1, low2;
  logic signed [ERR_W-1:0]  x1, x2;
  pidw_tag_t                t1, t2;
  logic [U_W+RECIP_W-1:0]   prod;
  logic [Q_W-1:0]           q2;
  logic [U_W-1:0]           qm;
  logic [U_W-1:0]           rem;
  logic [RC_W-1:0]          rc;
  logic signed [BASE_W:0]   y;

  // shift by half a turn, split off the low bits, offset the rest to be non-negative
  always_comb begin
    s    = $signed({x_in[ERR_W-1], x_in}) + $signed((ERR_W+1)'(HALF_TURN));
    hi   = s[ERR_W:LOW_BITS];
    u_in = {hi[HI_W-1], hi} + U_W'(WRAP_OFFSET);
  end

  assign prod = u1 * RECIP_W'(WRAP_RECIP);

  // remainder by the turn count, one correction step
  always_comb begin
    qm  = U_W'(q2 * WRAP_DIV);
    rem = u2 - qm;
    rc  = (rem >= U_W'(WRAP_DIV)) ? RC_W'(rem - U_W'(WRAP_DIV)) : RC_W'(rem);
    y   = $signed({1'b0, rc, low2}) - $signed((BASE_W+1)'(HALF_TURN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid      <= 1'b0;
      t2.valid      <= 1'b0;
      tag_out.valid <= 1'b0;
    end else if (en) begin
      t1      <= tag_in;
      t2      <= t1;
      tag_out <= t2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1    <= u_in;
      low1  <= s[LOW_BITS-1:0];
      x1    <= x_in;
      u2    <= u1;
      low2  <= low1;
      x2    <= x1;
      q2    <= prod[RECIP_SHIFT +: Q_W];
      x_out <= angle_mode ? {{(ERR_W-BASE_W-1){y[BASE_W]}}, y} : x2;
    end
  end

endmodule

### rtl/core/pidw_front.sv
module pidw_front import pidw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     angle_mode,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic signed [DATA_W-1:0] target,
  input  logic signed [DATA_W-1:0] measured,
  output logic                     push,
  output pidw_item_t               push_item,
  input  logic                     full
);

  logic                    en;
  pidw_tag_t               a_tag, wa_tag, d_tag, wb_tag;
  logic signed [ERR_W-1:0] wa_x, wb_x;
  logic signed [ERR_W-1:0] d_diff;
  logic signed [ERR_W-1:0] last_error;

  // whole front moves together; it holds only when a finished word meets a full queue
  assign en       = !(wb_tag.valid && full);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag.valid <= 1'b0;
      d_tag.valid <= 1'b0;
      last_error  <= '0;
    end else if (en) begin
      a_tag.valid <= in_valid;
      a_tag.kind  <= kind;
      a_tag.err   <= $signed({{(ERR_W-DATA_W){target[DATA_W-1]}}, target})
                   - $signed({{(ERR_W-DATA_W){measured[DATA_W-1]}}, measured});
      d_tag.valid <= wa_tag.valid;
      d_tag.kind  <= wa_tag.kind;
      d_tag.err   <= wa_x;
      d_diff      <= wa_x - last_error;
      if (wa_tag.valid) begin
        last_error <= (wa_tag.kind == KIND_CLEAR) ? '0 : wa_x;
      end
    end
  end

  pidw_wrap u_wrap_err (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .angle_mode (angle_mode),
    .tag_in     (a_tag),
    .x_in       (a_tag.err),
    .tag_out    (wa_tag),
    .x_out      (wa_x)
  );

  pidw_wrap u_wrap_diff (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .angle_mode (angle_mode),
    .tag_in     (d_tag),
    .x_in       (d_diff),
    .tag_out    (wb_tag),
    .x_out      (wb_x)
  );

  assign push           = en && wb_tag.valid;
  assign push_item.kind = wb_tag.kind;
  assign push_item.err  = wb_tag.err;
  assign push_item.diff = wb_x;

endmodule

### rtl/core/pidw_fifo.sv
module pidw_fifo import pidw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pidw_item_t push_item,
  input  logic       pop,
  output pidw_item_t head,
  output logic       empty,
  output logic       full
);

  pidw_item_t            slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

### rtl/core/pidw_back.sv
module pidw_back import pidw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  pidw_cfg_t                cfg,
  input  logic                     empty,
  input  pidw_item_t               head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] drive,
  output logic signed [ERR_W-1:0]  error_now
);

  logic                     ben;
  logic signed [MH_W-1:0]   p_hi, i_hi, d_hi;
  logic signed [ML_W-1:0]   p_lo, i_lo, d_lo;
  logic                     b1_v, b2_v, b3_v, b4_v;
  logic                     b1_kind, b2_kind, b3_kind, b4_kind;
  logic signed [ERR_W-1:0]  b1_err, b2_err, b3_err, b4_err;
  logic signed [TERM_W-1:0] p2, i2, d2;
  logic signed [TERM_W:0]   isum;
  logic signed [DATA_W-1:0] integ_new;
  logic signed [DATA_W-1:0] integral;
  logic signed [TERM_W:0]   pd3;
  logic signed [DATA_W-1:0] ig3;
  logic signed [SUM_W-1:0]  tot4;
  logic signed [LIM_W+1:0]  wl_s, ol_s;

  assign ben = !out_valid || !out_stall;
  assign pop = ben && !empty;

  always_ff @(posedge clk) begin
    if (ben) begin
      p_hi <= $signed(cfg.gain_p) * $signed(head.err[ERR_W-1:XL_W]);
      p_lo <= $signed(cfg.gain_p) * $signed({1'b0, head.err[XL_W-1:0]});
      i_hi <= $signed(cfg.gain_i) * $signed(head.err[ERR_W-1:XL_W]);
      i_lo <= $signed(cfg.gain_i) * $signed({1'b0, head.err[XL_W-1:0]});
      d_hi <= $signed(cfg.gain_d) * $signed(head.diff[ERR_W-1:XL_W]);
      d_lo <= $signed(cfg.gain_d) * $signed({1'b0, head.diff[XL_W-1:0]});
    end
  end

  // integral loop closes in one stage: add, then clamp
  always_comb begin
    isum      = $signed({integral[DATA_W-1], {(TERM_W-DATA_W){integral[DATA_W-1]}}, integral})
              + $signed({i2[TERM_W-1], i2});
    integ_new = clamp_sym(SUM_W'(isum), cfg.windup_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v      <= 1'b0;
      b2_v      <= 1'b0;
      b3_v      <= 1'b0;
      b4_v      <= 1'b0;
      out_valid <= 1'b0;
      integral  <= '0;
    end else if (ben) begin
      b1_v      <= !empty;
      b2_v      <= b1_v;
      b3_v      <= b2_v;
      b4_v      <= b3_v;
      out_valid <= b4_v;
      if (b2_v) begin
        integral <= (b2_kind == KIND_CLEAR) ? '0 : integ_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      b1_kind   <= head.kind;
      b1_err    <= head.err;
      b2_kind   <= b1_kind;
      b2_err    <= b1_err;
      p2        <= join_shift(p_hi, p_lo);
      i2        <= join_shift(i_hi, i_lo);
      d2        <= join_shift(d_hi, d_lo);
      b3_kind   <= b2_kind;
      b3_err    <= b2_err;
      pd3       <= $signed({p2[TERM_W-1], p2}) + $signed({d2[TERM_W-1], d2});
      ig3       <= integ_new;
      b4_kind   <= b3_kind;
      b4_err    <= b3_err;
      tot4      <= SUM_W'(pd3) + SUM_W'(ig3);
      drive     <= (b4_kind == KIND_CLEAR) ? '0 : clamp_sym(tot4, cfg.output_limit);
      error_now <= (b4_kind == KIND_CLEAR) ? '0 : b4_err;
    end
  end

  assign wl_s = $signed({2'b00, cfg.windup_limit});
  assign ol_s = $signed({2'b00, cfg.output_limit});

  a_integral_bounded: assert property (@(posedge clk) disable iff (rst)
    (ben && b2_v) |=> (integral <= wl_s && integral >= -wl_s))
    else $error("integral outside windup limit after update");

  a_drive_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive <= ol_s && drive >= -ol_s))
    else $error("drive outside output limit");

endmodule

### rtl/core/pid_controller_with_angle_wrap.sv
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall   | kind, target, measured
// result  | out       | out_valid / out_stall | drive, error_now
// config  | in        | cfg_write_en          | cfg_index, cfg_data
//
// sustained rate one word per clock while neither in_stall nor out_stall holds the flow
// pipeline: 8 front stages (error, wrap x3, difference, wrap x3), the queue, 5 back stages
// in_stall rises only while the two-entry queue is full and the front has a word ready
// out_stall holds the back pipeline while out_valid is high; the queue then absorbs the front's output
// rst is synchronous: clears the config registers, integral, last error and all valid bits
module pid_controller_with_angle_wrap import pidw_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]           cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic signed [DATA_W-1:0]    target,
  input  logic signed [DATA_W-1:0]    measured,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [DATA_W-1:0]    drive,
  output logic signed [ERR_W-1:0]     error_now
);

  pidw_cfg_t  cfg;
  logic       push, pop, empty, full;
  pidw_item_t push_item, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write_en) begin
      case (pidw_reg_t'(cfg_index))
        REG_GAIN_P:       cfg.gain_p       <= cfg_data;
        REG_GAIN_I:       cfg.gain_i       <= cfg_data;
        REG_GAIN_D:       cfg.gain_d       <= cfg_data;
        REG_OUTPUT_LIMIT: cfg.output_limit <= cfg_data[LIM_W-1:0];
        REG_WINDUP_LIMIT: cfg.windup_limit <= cfg_data[LIM_W-1:0];
        REG_ANGLE_MODE:   cfg.angle_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pidw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .angle_mode (cfg.angle_mode),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .target     (target),
    .measured   (measured),
    .push       (push),
    .push_item  (push_item),
    .full       (full)
  );

  pidw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  pidw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .error_now (error_now)
  );

endmodule

### bench/pid_checker.sv
`timescale 1ns / 1ps
module pid_checker import pidw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     kind,
  input  logic signed [DATA_W-1:0] target,
  input  logic signed [DATA_W-1:0] measured,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] drive,
  input  logic signed [ERR_W-1:0]  error_now,
  output int                       mismatches,
  output int                       backlog
);

  typedef logic signed [71:0] wide_t;

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic signed [ERR_W-1:0]  error_now;
  } pid_word_t;

  localparam wide_t HALF_W = wide_t'(180) <<< FRAC_BITS;
  localparam wide_t TURN_W = wide_t'(360) <<< FRAC_BITS;

  logic signed [DATA_W-1:0] gain_p_q = '0;
  logic signed [DATA_W-1:0] gain_i_q = '0;
  logic signed [DATA_W-1:0] gain_d_q = '0;
  logic [LIM_W-1:0]         drive_lim_q = '0;
  logic [LIM_W-1:0]         integ_lim_q = '0;
  logic                     wrap_on_q = 1'b0;
  logic signed [DATA_W-1:0] integ_q = '0;
  logic signed [ERR_W-1:0]  prev_err_q = '0;
  pid_word_t                expected_drive_q[$];
  int                       bad = 0;

  // floor(gain * x / 2^FRAC_BITS)
  function automatic wide_t scaled(logic signed [DATA_W-1:0] gain, wide_t x);
    wide_t p;
    p = wide_t'(gain) * x;
    return p >>> FRAC_BITS;
  endfunction

  function automatic wide_t wrap_turn(wide_t x);
    wide_t r;
    r = (x + HALF_W) % TURN_W;
    if (r < 0) begin
      r = r + TURN_W;
    end
    return r - HALF_W;
  endfunction

  function automatic wide_t clamp_to(wide_t v, logic [LIM_W-1:0] lim);
    wide_t l;
    l = '0;
    l[LIM_W-1:0] = lim;
    if (v >= l) begin
      return l;
    end
    if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

  function automatic pid_word_t predict_word(logic k, logic signed [DATA_W-1:0] t,
                                             logic signed [DATA_W-1:0] m);
    pid_word_t w;
    wide_t     err;
    wide_t     diff;
    wide_t     integ;
    wide_t     total;
    if (k == KIND_CLEAR) begin
      integ_q = '0;
      prev_err_q = '0;
      w.drive = '0;
      w.error_now = '0;
      return w;
    end
    err = wide_t'(t) - wide_t'(m);
    if (wrap_on_q) begin
      err = wrap_turn(err);
    end
    integ = clamp_to(wide_t'(integ_q) + scaled(gain_i_q, err), integ_lim_q);
    diff = err - wide_t'(prev_err_q);
    if (wrap_on_q) begin
      diff = wrap_turn(diff);
    end
    total = clamp_to(scaled(gain_p_q, err) + integ + scaled(gain_d_q, diff), drive_lim_q);
    integ_q = integ[DATA_W-1:0];
    prev_err_q = err[ERR_W-1:0];
    w.drive = total[DATA_W-1:0];
    w.error_now = err[ERR_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    pid_word_t want;
    if (rst) begin
      gain_p_q = '0;
      gain_i_q = '0;
      gain_d_q = '0;
      drive_lim_q = '0;
      integ_lim_q = '0;
      wrap_on_q = 1'b0;
      integ_q = '0;
      prev_err_q = '0;
      expected_drive_q.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_GAIN_P:       gain_p_q = cfg_data;
          REG_GAIN_I:       gain_i_q = cfg_data;
          REG_GAIN_D:       gain_d_q = cfg_data;
          REG_OUTPUT_LIMIT: drive_lim_q = cfg_data[LIM_W-1:0];
          REG_WINDUP_LIMIT: integ_lim_q = cfg_data[LIM_W-1:0];
          REG_ANGLE_MODE:   wrap_on_q = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_drive_q.size() == 0) begin
          $error("result word with nothing expected: drive %0d, error_now %0d",
                 drive, error_now);
          bad++;
        end else begin
          want = expected_drive_q.pop_front();
          if (drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, drive);
            bad++;
          end
          if (error_now !== want.error_now) begin
            $error("error_now: expected %0d, got %0d", want.error_now, error_now);
            bad++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_drive_q.push_back(predict_word(kind, target, measured));
      end
    end
    mismatches <= bad;
    backlog <= expected_drive_q.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top import pidw_pkg::*; ();

  localparam logic                     KIND_UPDATE = ~KIND_CLEAR;
  localparam logic [CFG_IDX_W-1:0]     REG_SPARE = 3'd7;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam int ONE             = 1 << FRAC_BITS;
  localparam int DEG180          = 180 << FRAC_BITS;
  localparam int HOLD_CYCLES     = 200;
  localparam int WORDS_PER_PHASE = 325;
  localparam int PHASES          = 6;
  localparam int SETTLE_CYCLES   = 40;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     kind = KIND_UPDATE;
  logic signed [DATA_W-1:0] target = '0;
  logic signed [DATA_W-1:0] measured = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] drive;
  logic signed [ERR_W-1:0]  error_now;
  int                       mismatches;
  int                       backlog;
  logic                     calm = 1'b0;
  logic                     hold_off_req = 1'b0;

  pid_controller_with_angle_wrap i_dut (.*);

  pid_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic send_word(input logic k, input logic signed [DATA_W-1:0] t,
                           input logic signed [DATA_W-1:0] m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    target <= t;
    measured <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender until every expected word is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
    end
    if (r < 75) begin
      return int'($urandom_range(0, 2 * ONE)) - ONE;
    end
    if (r < 90) begin
      return $urandom;
    end
    return ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
  endfunction

  function automatic logic [DATA_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return '0;
    end
    if (r < 25) begin
      return 32'hffff_ffff;
    end
    if (r < 75) begin
      return $urandom_range(1, 2000 * ONE);
    end
    return $urandom;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_corner();
    case ($urandom_range(0, 5))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return '0;
      3: return -1;
      4: return DEG180;
      default: return -DEG180;
    endcase
  endfunction

  task automatic random_settings();
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, pick_gain());
    write_reg(REG_GAIN_D, pick_gain());
    write_reg(REG_OUTPUT_LIMIT, pick_limit());
    write_reg(REG_WINDUP_LIMIT, pick_limit());
    write_reg(REG_ANGLE_MODE, $urandom);
  endtask

  task automatic send_random_word();
    int                       pick;
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] m;
    pick = $urandom_range(0, 99);
    t = $urandom;
    m = $urandom;
    if (pick < 5) begin
      send_word(KIND_CLEAR, t, m);
    end else begin
      if (pick < 45) begin
        // angles within a couple of turns
        t = int'($urandom_range(0, 8 * DEG180)) - 4 * DEG180;
        m = int'($urandom_range(0, 8 * DEG180)) - 4 * DEG180;
      end else if (pick < 70) begin
        // feedback tracking the setpoint closely
        m = t - (int'($urandom_range(0, 8 * ONE)) - 4 * ONE);
      end else if (pick < 85) begin
        // errors right on and around the wrap boundaries
        t = (int'($urandom_range(0, 6)) - 3) * DEG180 + int'($urandom_range(0, 4)) - 2;
        m = int'($urandom_range(0, 2)) - 1;
      end else if (pick >= 95) begin
        t = pick_corner();
        m = pick_corner();
      end
      send_word(KIND_UPDATE, t, m);
    end
  endtask

  // result side back-pressure
  initial begin
    int gap;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all registers at reset value
    send_word(KIND_UPDATE, S32_MAX, S32_MIN);
    drain();

    write_reg(REG_GAIN_P, ONE);
    write_reg(REG_GAIN_I, ONE / 2);
    write_reg(REG_GAIN_D, -ONE / 4);
    write_reg(REG_OUTPUT_LIMIT, S32_MAX);
    write_reg(REG_WINDUP_LIMIT, S32_MAX);
    write_reg(REG_ANGLE_MODE, '0);
    send_word(KIND_UPDATE, S32_MAX, S32_MIN);
    send_word(KIND_UPDATE, S32_MIN, S32_MAX);
    send_word(KIND_UPDATE, 0, 0);
    send_word(KIND_UPDATE, -1, 0);
    send_word(KIND_CLEAR, S32_MAX, S32_MIN);
    send_word(KIND_UPDATE, 1, 0);
    drain();

    // extreme gains, tight integral clamp
    write_reg(REG_GAIN_P, S32_MIN);
    write_reg(REG_GAIN_I, S32_MAX);
    write_reg(REG_GAIN_D, S32_MIN);
    write_reg(REG_OUTPUT_LIMIT, 32'hffff_ffff);
    write_reg(REG_WINDUP_LIMIT, ONE);
    send_word(KIND_UPDATE, S32_MAX, S32_MIN);
    send_word(KIND_UPDATE, S32_MIN, S32_MAX);
    send_word(KIND_UPDATE, S32_MAX, S32_MAX);
    send_word(KIND_CLEAR, -1, -1);
    send_word(KIND_UPDATE, 0, 1);
    drain();

    // angle mode around the half turn
    write_reg(REG_GAIN_P, ONE);
    write_reg(REG_GAIN_I, ONE / 16);
    write_reg(REG_GAIN_D, ONE);
    write_reg(REG_OUTPUT_LIMIT, 400 * ONE);
    write_reg(REG_WINDUP_LIMIT, 90 * ONE);
    write_reg(REG_ANGLE_MODE, 32'hffff_ffff);
    write_reg(REG_SPARE, $urandom);
    send_word(KIND_UPDATE, DEG180, 0);
    send_word(KIND_UPDATE, 0, DEG180);
    send_word(KIND_CLEAR, 0, 0);
    send_word(KIND_UPDATE, DEG180 - 1, 0);
    send_word(KIND_UPDATE, -DEG180 + ONE, 0);
    send_word(KIND_UPDATE, 3 * DEG180, 0);
    send_word(KIND_UPDATE, S32_MIN, S32_MAX);
    send_word(KIND_UPDATE, S32_MAX, S32_MIN);
    drain();

    // previous error carried across a mode change
    write_reg(REG_ANGLE_MODE, '0);
    send_word(KIND_UPDATE, 300 * ONE, 0);
    drain();
    write_reg(REG_ANGLE_MODE, 1);
    send_word(KIND_UPDATE, 0, 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      random_settings();
      calm = (p < 2);
      if (p == 1) begin
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_random_word();
      end
      drain();
      calm = 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
